[sv/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, constants and the CORDIC arctangent table for the
// Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int IN_W  = 22;  // angle input width
  localparam int CW    = 34;  // CORDIC / Q30 datapath width
  localparam int PW    = 54;  // magnitude times pi product width
  localparam int TW    = 40;  // dividend width for the divide by 360
  localparam int QW    = 31;  // radian quotient width
  localparam int DW    = 10;  // digit width of the reciprocal multiply
  localparam int ND    = 4;   // dividend digits, TW / DW
  localparam int AW    = 52;  // reciprocal multiply accumulator width
  localparam int RECIP_SH = 49;                         // reciprocal scale, 2^49
  localparam int Q_LSB    = RECIP_SH - DW * (ND - 1);   // quotient LSB in the accumulator
  localparam int SC_FIXED_LAT = 9;  // sine/cosine lane latency without CORDIC steps

  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [31:0] K_Q30     = 32'd652032874;
  localparam logic [40:0] RECIP_360 = 41'd1563749870615;  // ceil(2^49 / 360)

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000007;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q30 product rounding: add half an LSB, floor shift by 30.
  function automatic logic signed [CW-1:0] rnd_q30(input logic signed [2*CW-1:0] p);
    logic signed [2*CW-1:0] s;
    s = p + (2*CW)'(64'sd536870912);
    return CW'(s >>> 30);
  endfunction

endpackage

[sv/e2q_div_cell.sv]
// ----------------------------------------------------------------------------
// e2q_div_cell
// One dividend digit of the pipelined multiply by the reciprocal of 360.
// ----------------------------------------------------------------------------
module e2q_div_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk_i,
  input  logic [e2q_pkg::AW-1:0]   acc_i,
  input  logic [e2q_pkg::TW-1:0]   num_i,
  input  logic                     neg_i,
  input  logic                     flip_i,
  output logic [e2q_pkg::AW-1:0]   acc_o,
  output logic [e2q_pkg::TW-1:0]   num_o,
  output logic                     neg_o,
  output logic                     flip_o
);

  logic [e2q_pkg::DW-1:0] digit;
  logic [e2q_pkg::AW-1:0] part;

  // least significant digit first: drop the settled low bits, add this digit's product
  assign digit = num_i[IDX*e2q_pkg::DW +: e2q_pkg::DW];
  assign part  = e2q_pkg::AW'(digit) * e2q_pkg::AW'(e2q_pkg::RECIP_360);

  always_ff @(posedge clk_i) begin
    acc_o  <= (acc_i >> e2q_pkg::DW) + part;
    num_o  <= num_i;
    neg_o  <= neg_i;
    flip_o <= flip_i;
  end

endmodule

[sv/e2q_cordic_cell.sv]
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                           clk_i,
  input  logic signed [e2q_pkg::CW-1:0]  x_i,
  input  logic signed [e2q_pkg::CW-1:0]  y_i,
  input  logic signed [e2q_pkg::CW-1:0]  z_i,
  input  logic                           flip_i,
  output logic signed [e2q_pkg::CW-1:0]  x_o,
  output logic signed [e2q_pkg::CW-1:0]  y_o,
  output logic signed [e2q_pkg::CW-1:0]  z_o,
  output logic                           flip_o
);

  localparam logic signed [e2q_pkg::CW-1:0] ATAN =
    e2q_pkg::CW'(e2q_pkg::atan_q30(STEP));

  logic signed [e2q_pkg::CW-1:0] xs;
  logic signed [e2q_pkg::CW-1:0] ys;
  logic                          pos;

  assign xs  = x_i >>> STEP;
  assign ys  = y_i >>> STEP;
  assign pos = !z_i[e2q_pkg::CW-1];

  always_ff @(posedge clk_i) begin
    x_o    <= pos ? x_i - ys : x_i + ys;
    y_o    <= pos ? y_i + xs : y_i - xs;
    z_o    <= pos ? z_i - ATAN : z_i + ATAN;
    flip_o <= flip_i;
  end

endmodule

[sv/e2q_sincos.sv]
// ----------------------------------------------------------------------------
// e2q_sincos
// Sine and cosine of half an angle: saturate, fold, scale to radians,
// divide by 360 through a reciprocal-multiply cell chain, then a CORDIC
// cell chain.
// ----------------------------------------------------------------------------
module e2q_sincos #(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int NSTEP           = 18
) (
  input  logic                             clk_i,
  input  logic signed [e2q_pkg::IN_W-1:0]  angle_i,
  output logic signed [e2q_pkg::CW-1:0]    sin_o,
  output logic signed [e2q_pkg::CW-1:0]    cos_o
);

  localparam logic signed [47:0] FULL  = 48'sd360 <<< ANGLE_FRAC_BITS;
  localparam logic signed [47:0] QUART = 48'sd180 <<< ANGLE_FRAC_BITS;
  localparam logic [55:0]        HALF  = 56'd180 << ANGLE_FRAC_BITS;

  logic signed [47:0] ext, sat, red;
  logic               flip;
  logic [47:0]        mag;

  logic [e2q_pkg::IN_W-1:0] mag_q;
  logic                     neg_q, flip_q;
  logic [e2q_pkg::PW-1:0]   prod_q;
  logic                     neg1_q, flip1_q;
  logic [55:0]              tsum;
  logic [55:0]              tshift;
  logic [e2q_pkg::TW-1:0]   num_q;
  logic                     neg2_q, flip2_q;

  // saturate to one turn, fold the half angle into +-90 degrees
  always_comb begin
    ext  = 48'(angle_i);
    sat  = ext;
    if (ext > FULL)  sat = FULL;
    if (ext < -FULL) sat = -FULL;
    red  = sat;
    flip = 1'b0;
    if (sat > QUART) begin
      red  = sat - FULL;
      flip = 1'b1;
    end else if (sat < -QUART) begin
      red  = sat + FULL;
      flip = 1'b1;
    end
    mag = red[47] ? 48'(-red) : 48'(red);
  end

  assign tsum   = 56'(prod_q) + HALF;
  assign tshift = tsum >> ANGLE_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    mag_q   <= mag[e2q_pkg::IN_W-1:0];
    neg_q   <= red[47];
    flip_q  <= flip;
    prod_q  <= e2q_pkg::PW'(mag_q) * e2q_pkg::PW'(e2q_pkg::PI_Q30);
    neg1_q  <= neg_q;
    flip1_q <= flip_q;
    num_q   <= tshift[e2q_pkg::TW-1:0];
    neg2_q  <= neg1_q;
    flip2_q <= flip1_q;
  end

  // divide by 360: multiply by ceil(2^49 / 360), one dividend digit per cell
  logic [e2q_pkg::AW-1:0] dacc  [0:e2q_pkg::ND];
  logic [e2q_pkg::TW-1:0] dnum  [0:e2q_pkg::ND];
  logic                   dneg  [0:e2q_pkg::ND];
  logic                   dflip [0:e2q_pkg::ND];

  assign dacc[0]  = '0;
  assign dnum[0]  = num_q;
  assign dneg[0]  = neg2_q;
  assign dflip[0] = flip2_q;

  for (genvar k = 0; k < e2q_pkg::ND; k++) begin : g_div
    e2q_div_cell #(.IDX(k)) u_cell (
      .clk_i  (clk_i),
      .acc_i  (dacc[k]),
      .num_i  (dnum[k]),
      .neg_i  (dneg[k]),
      .flip_i (dflip[k]),
      .acc_o  (dacc[k+1]),
      .num_o  (dnum[k+1]),
      .neg_o  (dneg[k+1]),
      .flip_o (dflip[k+1])
    );
  end

  // signed radians in Q30, seed the CORDIC
  logic signed [e2q_pkg::CW-1:0] cx [0:NSTEP];
  logic signed [e2q_pkg::CW-1:0] cy [0:NSTEP];
  logic signed [e2q_pkg::CW-1:0] cz [0:NSTEP];
  logic                          cf [0:NSTEP];
  logic signed [e2q_pkg::CW-1:0] theta;
  logic signed [e2q_pkg::CW-1:0] z0_q;
  logic                          f0_q;

  assign theta = e2q_pkg::CW'(dacc[e2q_pkg::ND][e2q_pkg::Q_LSB +: e2q_pkg::QW]);

  always_ff @(posedge clk_i) begin
    z0_q <= dneg[e2q_pkg::ND] ? -theta : theta;
    f0_q <= dflip[e2q_pkg::ND];
  end

  assign cx[0] = e2q_pkg::CW'(e2q_pkg::K_Q30);
  assign cy[0] = '0;
  assign cz[0] = z0_q;
  assign cf[0] = f0_q;

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    e2q_cordic_cell #(.STEP(i)) u_cell (
      .clk_i  (clk_i),
      .x_i    (cx[i]),
      .y_i    (cy[i]),
      .z_i    (cz[i]),
      .flip_i (cf[i]),
      .x_o    (cx[i+1]),
      .y_o    (cy[i+1]),
      .z_o    (cz[i+1]),
      .flip_o (cf[i+1])
    );
  end

  // undo the 180 degree fold
  always_ff @(posedge clk_i) begin
    sin_o <= cf[NSTEP] ? -cy[NSTEP] : cy[NSTEP];
    cos_o <= cf[NSTEP] ? -cx[NSTEP] : cx[NSTEP];
  end

endmodule

[sv/euler_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (heading, pitch, roll) to a unit quaternion in Q1.16.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  angles   | heading_i, pitch_i, roll_i              | start_i high, busy_o low
//  quat     | quat_x_o, quat_y_o, quat_z_o, quat_w_o  | done_o strobe, one cycle
//
//  One transfer is taken every cycle; busy_o is never raised.
//  The pipeline holds three front stages, four reciprocal-multiply cells for
//  the divide by 360, one radian stage, one cell per CORDIC step (at most 32),
//  one fold stage, then six product and rounding stages.
//  Reset clears only the valid pipeline; data stages hold no reset.
//  The receiver cannot stall, so results leave on done_o without backpressure.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int OUT_FRAC_BITS   = 16,
  parameter int CORDIC_STEPS    = 18
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [e2q_pkg::IN_W-1:0]  heading_i,
  input  logic signed [e2q_pkg::IN_W-1:0]  pitch_i,
  input  logic signed [e2q_pkg::IN_W-1:0]  roll_i,
  output logic                             done_o,
  output logic signed [OUT_FRAC_BITS+1:0]  quat_x_o,
  output logic signed [OUT_FRAC_BITS+1:0]  quat_y_o,
  output logic signed [OUT_FRAC_BITS+1:0]  quat_z_o,
  output logic signed [OUT_FRAC_BITS+1:0]  quat_w_o
);

  localparam int CW    = e2q_pkg::CW;
  localparam int OW    = OUT_FRAC_BITS + 2;
  localparam int NSTEP = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int LAT   = e2q_pkg::SC_FIXED_LAT + NSTEP + 6;
  localparam int SH    = 30 - OUT_FRAC_BITS;
  localparam logic signed [CW:0] RND_O = (SH > 0) ? (CW+1)'(64'sd1 <<< (SH - 1)) : '0;
  localparam logic signed [CW:0] ONE   = (CW+1)'(64'sd1 <<< OUT_FRAC_BITS);

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // valid pipeline: advance every cycle
  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end
  assign done_o = vld_q[LAT-1];

  // three half-angle sine/cosine lanes
  logic signed [CW-1:0] sh, ch, sp, cp, sr, cr;

  e2q_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .NSTEP(NSTEP)) u_head (
    .clk_i(clk_i), .angle_i(heading_i), .sin_o(sh), .cos_o(ch)
  );
  e2q_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .NSTEP(NSTEP)) u_pitch (
    .clk_i(clk_i), .angle_i(pitch_i), .sin_o(sp), .cos_o(cp)
  );
  e2q_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .NSTEP(NSTEP)) u_roll (
    .clk_i(clk_i), .angle_i(roll_i), .sin_o(sr), .cos_o(cr)
  );

  // pitch-heading products: raw, then rounded; hold roll alongside
  logic signed [2*CW-1:0] p_cc_q, p_ss_q, p_sc_q, p_cs_q;
  logic signed [CW-1:0]   cc_q, ss_q, sc_q, cs_q;
  logic signed [CW-1:0]   sr1_q, cr1_q, sr2_q, cr2_q;

  always_ff @(posedge clk_i) begin
    p_cc_q <= (2*CW)'(cp) * (2*CW)'(ch);
    p_ss_q <= (2*CW)'(sp) * (2*CW)'(sh);
    p_sc_q <= (2*CW)'(sp) * (2*CW)'(ch);
    p_cs_q <= (2*CW)'(cp) * (2*CW)'(sh);
    sr1_q  <= sr;
    cr1_q  <= cr;
    cc_q   <= e2q_pkg::rnd_q30(p_cc_q);
    ss_q   <= e2q_pkg::rnd_q30(p_ss_q);
    sc_q   <= e2q_pkg::rnd_q30(p_sc_q);
    cs_q   <= e2q_pkg::rnd_q30(p_cs_q);
    sr2_q  <= sr1_q;
    cr2_q  <= cr1_q;
  end

  // roll products: raw, then rounded
  logic signed [2*CW-1:0] m_q [0:7];
  logic signed [CW-1:0]   r_q [0:7];

  always_ff @(posedge clk_i) begin
    m_q[0] <= (2*CW)'(sr2_q) * (2*CW)'(cc_q);
    m_q[1] <= (2*CW)'(cr2_q) * (2*CW)'(ss_q);
    m_q[2] <= (2*CW)'(cr2_q) * (2*CW)'(sc_q);
    m_q[3] <= (2*CW)'(sr2_q) * (2*CW)'(cs_q);
    m_q[4] <= (2*CW)'(cr2_q) * (2*CW)'(cs_q);
    m_q[5] <= (2*CW)'(sr2_q) * (2*CW)'(sc_q);
    m_q[6] <= (2*CW)'(cr2_q) * (2*CW)'(cc_q);
    m_q[7] <= (2*CW)'(sr2_q) * (2*CW)'(ss_q);
    for (int k = 0; k < 8; k++) begin
      r_q[k] <= e2q_pkg::rnd_q30(m_q[k]);
    end
  end

  // combine the terms
  logic signed [CW:0] sum_q [0:3];
  always_ff @(posedge clk_i) begin
    sum_q[0] <= (CW+1)'(r_q[0]) - (CW+1)'(r_q[1]);
    sum_q[1] <= (CW+1)'(r_q[2]) + (CW+1)'(r_q[3]);
    sum_q[2] <= (CW+1)'(r_q[4]) - (CW+1)'(r_q[5]);
    sum_q[3] <= (CW+1)'(r_q[6]) + (CW+1)'(r_q[7]);
  end

  // round to the output format and clamp to +-1.0
  logic signed [CW:0] rv [0:3];
  logic signed [CW:0] cv [0:3];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rv[k] = (sum_q[k] + RND_O) >>> SH;
      cv[k] = rv[k];
      if (rv[k] > ONE)  cv[k] = ONE;
      if (rv[k] < -ONE) cv[k] = -ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    quat_x_o <= OW'(cv[0]);
    quat_y_o <= OW'(cv[1]);
    quat_z_o <= OW'(cv[2]);
    quat_w_o <= OW'(cv[3]);
  end

  // an accepted transfer enters the valid pipeline on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept) && $past(rst_ni) |-> vld_q[0])
    else $error("accepted transfer lost at pipeline entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_x_o <= OW'(ONE)) && (quat_x_o >= -OW'(ONE))
            && (quat_y_o <= OW'(ONE)) && (quat_y_o >= -OW'(ONE)))
    else $error("x or y component beyond unit range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_z_o <= OW'(ONE)) && (quat_z_o >= -OW'(ONE))
            && (quat_w_o <= OW'(ONE)) && (quat_w_o >= -OW'(ONE)))
    else $error("z or w component beyond unit range");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for euler_to_quaternion: drives heading, pitch and roll
// triples on the start/busy command port, predicts each quaternion with a
// bit-exact fixed-point CORDIC model and checks every done_o strobe in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int AFB    = 12;
  localparam int OFB    = 16;
  localparam int STEPS  = 18;
  localparam int OW     = OFB + 2;
  localparam int LAT    = 15 + STEPS;
  localparam longint FULL_ANG = 360 * (1 << AFB);
  localparam longint HALF_ANG = 180 * (1 << AFB);

  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
    logic signed [OW-1:0] w;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [e2q_pkg::IN_W-1:0] heading_i = '0;
  logic signed [e2q_pkg::IN_W-1:0] pitch_i = '0;
  logic signed [e2q_pkg::IN_W-1:0] roll_i = '0;
  logic done_o;
  logic signed [OW-1:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  quat_t quat_fifo[$];
  int    n_errors = 0;

  euler_to_quaternion #(
    .ANGLE_FRAC_BITS(AFB),
    .OUT_FRAC_BITS  (OFB),
    .CORDIC_STEPS   (STEPS)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .heading_i(heading_i),
    .pitch_i  (pitch_i),
    .roll_i   (roll_i),
    .done_o   (done_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o),
    .quat_w_o (quat_w_o)
  );

  always #5 clk_i = ~clk_i;

  // Arctangent table, truncated Q30.
  function automatic longint atan_q30_tab(input int i);
    longint t[30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};
    return (i < 30) ? t[i] : 64'sd0;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Sine and cosine in Q30 of half the given angle.
  task automatic half_angle_sincos(input longint ang, output longint s, output longint c);
    longint q, theta, x, y, z, nx;
    bit     flip;
    flip = 1'b0;
    if (ang > FULL_ANG) ang = FULL_ANG;
    if (ang < -FULL_ANG) ang = -FULL_ANG;
    // fold half angles past 90 degrees, negate the result afterward
    if (ang > HALF_ANG) begin
      ang -= FULL_ANG;
      flip = 1'b1;
    end else if (ang < -HALF_ANG) begin
      ang += FULL_ANG;
      flip = 1'b1;
    end
    q = ((ang < 0 ? -ang : ang) * 64'sd3373259426 + FULL_ANG / 2) / FULL_ANG;
    theta = (ang < 0) ? -q : q;
    x = 64'sd652032874;
    y = 0;
    z = theta;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_q30_tab(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_q30_tab(i);
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic logic signed [OW-1:0] round_to_out(input longint v);
    longint one;
    one = 64'sd1 <<< OFB;
    v = (v + (64'sd1 <<< (29 - OFB))) >>> (30 - OFB);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return OW'(v);
  endfunction

  task automatic predict_quat(input longint h, input longint p, input longint r,
                              output quat_t q);
    longint sh, ch, sp, cp, sr, cr, cpch, spsh, spch, cpsh;
    half_angle_sincos(h, sh, ch);
    half_angle_sincos(p, sp, cp);
    half_angle_sincos(r, sr, cr);
    cpch = mul_q30(cp, ch);
    spsh = mul_q30(sp, sh);
    spch = mul_q30(sp, ch);
    cpsh = mul_q30(cp, sh);
    q.x = round_to_out(mul_q30(sr, cpch) - mul_q30(cr, spsh));
    q.y = round_to_out(mul_q30(cr, spch) + mul_q30(sr, cpsh));
    q.z = round_to_out(mul_q30(cr, cpsh) - mul_q30(sr, spch));
    q.w = round_to_out(mul_q30(cr, cpch) + mul_q30(sr, spsh));
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // Send one triple; hold start until the transfer, then drop it unless
  // the next item follows back to back.
  task automatic send_angles(input logic [21:0] h, input logic [21:0] p,
                             input logic [21:0] r, input int gap);
    quat_t q;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    heading_i <= h;
    pitch_i   <= p;
    roll_i    <= r;
    start_i   <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_quat(longint'($signed(h)), longint'($signed(p)), longint'($signed(r)), q);
    quat_fifo.push_back(q);
    @(negedge clk_i);
  endtask

  task automatic finish_burst();
    start_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Check each strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && done_o) begin
      if (quat_fifo.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = quat_fifo.pop_front();
        if (quat_x_o !== want.x) report_mismatch("quat_x", quat_x_o, want.x);
        if (quat_y_o !== want.y) report_mismatch("quat_y", quat_y_o, want.y);
        if (quat_z_o !== want.z) report_mismatch("quat_z", quat_z_o, want.z);
        if (quat_w_o !== want.w) report_mismatch("quat_w", quat_w_o, want.w);
      end
    end
  end

  function automatic logic [21:0] rand_angle();
    case ($urandom_range(0, 9))
      0:       return 22'($urandom);                       // anything, saturation too
      1:       return 22'($signed($urandom_range(0, 2949120)) - 1474560);
      default: return 22'($signed($urandom_range(0, 2949120)) - 1474560);
    endcase
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
  endfunction

  task automatic drain();
    finish_burst();
    while (quat_fifo.size() != 0) @(negedge clk_i);
  endtask

  // Extremes, range edges, the fold points and saturation.
  task automatic test_directed();
    logic [21:0] pts[12] = '{22'sd0, 22'sd1, -22'sd1, 22'sd737280, 22'sd737281,
      -22'sd737280, -22'sd737281, 22'sd1474560, -22'sd1474560, 22'sd1474561,
      22'h1FFFFF, 22'h200000};
    foreach (pts[i]) send_angles(pts[i], pts[(i + 3) % 12], pts[(i + 7) % 12], 0);
    send_angles(22'sd368640, 22'sd368640, 22'sd368640, 1);
    send_angles(22'sd0, 22'sd368640, 22'sd0, 0);   // gimbal region
    send_angles(22'sd0, 22'sd737280, 22'sd0, 0);
    send_angles(22'sd1474560, 22'sd1474560, 22'sd1474560, 0);
    drain();
  endtask

  // Random triples with random sender gaps.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_angles(rand_angle(), rand_angle(), rand_angle(), rand_gap());
    end
    finish_burst();
  endtask

  // Hold off until every expected result is back, then resume.
  task automatic test_pause_until_empty();
    test_random(50);
    drain();
    test_random(50);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_pause_until_empty();
    test_random(1400);
    drain();
    repeat (LAT + 10) @(negedge clk_i);
    if (n_errors == 0 && quat_fifo.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
sv/e2q_pkg.sv
sv/e2q_div_cell.sv
sv/e2q_cordic_cell.sv
sv/e2q_sincos.sv
sv/euler_to_quaternion.sv
test/tb.sv
